// ----- hw/rtl/argb_saturation_scaler_core_assert.svh -----
// ----------------------------------------------------------------------------
// argb_saturation_scaler_core assertion macros
// Concurrent check helpers; they compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ARGB_SATURATION_SCALER_CORE_ASSERT_SVH
`define ARGB_SATURATION_SCALER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/argbss_pkg.sv -----
// ----------------------------------------------------------------------------
// argbss_pkg
// Types, constants and helper functions of the ARGB saturation scaler.
// ----------------------------------------------------------------------------
package argbss_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int SW            = FRACTION_BITS + 1;
    localparam logic [SW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    localparam int HUE_NUM_W  = 14;
    localparam int DIV_STAGES = (SW > HUE_NUM_W) ? SW : HUE_NUM_W;

    localparam int SCALE_W = 9;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 9'd256;

    localparam logic REG_SAT_SCALE = 1'b0;

    typedef enum logic [5:0] {
        HC_RED_POS = 6'b000001,
        HC_RED_NEG = 6'b000010,
        HC_GRN_POS = 6'b000100,
        HC_GRN_NEG = 6'b001000,
        HC_BLU_POS = 6'b010000,
        HC_BLU_NEG = 6'b100000
    } hue_case_t;

    typedef struct packed {
        logic                 valid;
        logic [7:0]           alpha;
        logic [SW-1:0]        v;
        hue_case_t            hcase;
        logic [HUE_NUM_W-1:0] num;
        logic [HUE_NUM_W-1:0] hq;
        logic [7:0]           hrem;
        logic [7:0]           dd;
        logic [7:0]           mx;
        logic [7:0]           srem;
        logic [SW-1:0]        sq;
        logic                 grey;
    } div_t;

    // floor(m * ONE / 60), as a constant table over m = 0..59
    function automatic logic [SW-1:0] f_of(input logic [5:0] m);
        logic [SW-1:0] x;
        x = '0;
        for (int k = 0; k < 60; k++)
        begin
            if (m == 6'(k))
                x = SW'((longint'(k) << FRACTION_BITS) / 60);
        end
        return x;
    endfunction

    // ceil(mx * ONE / 255), as a constant table over every byte value
    function automatic logic [SW-1:0] v_of(input logic [7:0] mx);
        logic [SW-1:0] x;
        x = '0;
        for (int k = 0; k < 256; k++)
        begin
            if (mx == 8'(k))
                x = SW'(((longint'(k) << FRACTION_BITS) + 254) / 255);
        end
        return x;
    endfunction

    // floor(x * 255 / ONE), clamped to one byte
    function automatic logic [7:0] pack_channel(input logic [SW-1:0] x);
        logic [SW+7:0] prod;
        logic [7:0]    hi;
        prod = {x, 8'd0} - {8'd0, x};
        hi   = (prod[SW+7:FRACTION_BITS] > (SW+8-FRACTION_BITS)'(255)) ? 8'd255
             : prod[FRACTION_BITS+7:FRACTION_BITS];
        return hi;
    endfunction

    // One restoring step of both dividers; k is the stage number.
    function automatic div_t div_step(input div_t x, input int k);
        div_t       y;
        logic [8:0] ht;
        logic [8:0] st;
        logic       hb;
        logic       sb;
        y = x;
        if (k < HUE_NUM_W)
        begin
            ht     = {x.hrem, x.num[HUE_NUM_W-1-k]};
            hb     = ht >= {1'b0, x.dd};
            y.hrem = hb ? 8'(ht - {1'b0, x.dd}) : ht[7:0];
            y.hq   = {x.hq[HUE_NUM_W-2:0], hb};
        end
        if (k == 0)
        begin
            sb     = x.dd >= x.mx;
            y.srem = sb ? (x.dd - x.mx) : x.dd;
            y.sq   = {x.sq[SW-2:0], sb};
        end
        else if (k < SW)
        begin
            st     = {x.srem, 1'b0};
            sb     = st >= {1'b0, x.mx};
            y.srem = sb ? 8'(st - {1'b0, x.mx}) : st[7:0];
            y.sq   = {x.sq[SW-2:0], sb};
        end
        return y;
    endfunction

endpackage

// ----- hw/rtl/argb_saturation_scaler_core.sv -----
// ----------------------------------------------------------------------------
// argb_saturation_scaler_core
// Per-pixel HSV saturation scaling of an ARGB8888 stream.
// ----------------------------------------------------------------------------
// A pixel word is taken at every clock edge where start is high; busy is
// never raised, so one word per clock is sustained. Each word comes back on
// pixel_out with done high for exactly one cycle, after passing through one
// input register, DIV_STAGES divider stages (17 with 16 fraction bits, one
// quotient bit of the saturation divider per stage and of the hue divider in
// the first 14), and five stages for hue, scaling and the p/q/t multipliers.
// The bit-serial dividers make up most of that depth. Results come out in
// order and the receiver cannot stall them. saturation_scale (address 0,
// 9 bits, 8 fraction bits, reset 256 meaning unchanged) must be written over
// the APB port while the pipeline is empty; the block does not enforce this.
`include "argb_saturation_scaler_core_assert.svh"

module argb_saturation_scaler_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] pixel_in,
    output logic [31:0] pixel_out,
    output logic        done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FB = argbss_pkg::FRACTION_BITS;
    localparam int SW = argbss_pkg::SW;
    localparam int DS = argbss_pkg::DIV_STAGES;

    // ---------------- configuration ----------------
    logic [argbss_pkg::SCALE_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= argbss_pkg::SCALE_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == argbss_pkg::REG_SAT_SCALE)
            scale_reg <= pwdata[argbss_pkg::SCALE_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == argbss_pkg::REG_SAT_SCALE)
                  ? {{(32-argbss_pkg::SCALE_W){1'b0}}, scale_reg} : 32'd0;
    assign busy   = 1'b0;

    // ---------------- input decode ----------------
    logic [7:0] in_r, in_g, in_b, in_mx, in_mn, in_diff;
    argbss_pkg::hue_case_t in_case;
    argbss_pkg::div_t      in_next;

    always_comb
    begin
        in_r  = pixel_in[23:16];
        in_g  = pixel_in[15:8];
        in_b  = pixel_in[7:0];
        in_mx = in_r;
        if (in_g > in_mx) in_mx = in_g;
        if (in_b > in_mx) in_mx = in_b;
        in_mn = in_r;
        if (in_g < in_mn) in_mn = in_g;
        if (in_b < in_mn) in_mn = in_b;
        // ties go to red, then green
        if (in_r == in_mx)
        begin
            in_case = (in_g >= in_b) ? argbss_pkg::HC_RED_POS : argbss_pkg::HC_RED_NEG;
            in_diff = (in_g >= in_b) ? in_g - in_b : in_b - in_g;
        end
        else if (in_g == in_mx)
        begin
            in_case = (in_b >= in_r) ? argbss_pkg::HC_GRN_POS : argbss_pkg::HC_GRN_NEG;
            in_diff = (in_b >= in_r) ? in_b - in_r : in_r - in_b;
        end
        else
        begin
            in_case = (in_r >= in_g) ? argbss_pkg::HC_BLU_POS : argbss_pkg::HC_BLU_NEG;
            in_diff = (in_r >= in_g) ? in_r - in_g : in_g - in_r;
        end
        in_next       = '0;
        in_next.valid = start && !busy;
        in_next.alpha = pixel_in[31:24];
        in_next.v     = argbss_pkg::v_of(in_mx);
        in_next.hcase = in_case;
        in_next.num   = argbss_pkg::HUE_NUM_W'(in_diff) * argbss_pkg::HUE_NUM_W'(60);
        in_next.dd    = in_mx - in_mn;
        in_next.mx    = in_mx;
        in_next.grey  = (in_mx == in_mn);
    end

    // ---------------- divider pipeline ----------------
    argbss_pkg::div_t pipe_reg [DS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_reg[0].valid <= 1'b0;
        else
            pipe_reg[0] <= in_next;
    end

    for (genvar k = 0; k < DS; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pipe_reg[k+1].valid <= 1'b0;
            else
                pipe_reg[k+1] <= argbss_pkg::div_step(pipe_reg[k], k);
        end
    end

    // ---------------- stage A: hue and scaled saturation ----------------
    argbss_pkg::div_t dv;
    logic [argbss_pkg::HUE_NUM_W-1:0] hq_ceil;
    logic [8:0]            hue_next;
    logic [SW-1:0]         s_raw;
    logic [SW+8:0]         sprod;
    logic [SW:0]           sshift;
    logic [SW-1:0]         sat_next;

    always_comb
    begin
        dv      = pipe_reg[DS];
        hq_ceil = dv.hq + argbss_pkg::HUE_NUM_W'(dv.hrem != 8'd0);
        case (dv.hcase)
            argbss_pkg::HC_RED_POS: hue_next = dv.hq[8:0];
            argbss_pkg::HC_RED_NEG: hue_next = (dv.hq == '0) ? 9'd0 : 9'd360 - dv.hq[8:0];
            argbss_pkg::HC_GRN_POS: hue_next = 9'd120 + dv.hq[8:0];
            argbss_pkg::HC_GRN_NEG: hue_next = 9'd120 - hq_ceil[8:0];
            argbss_pkg::HC_BLU_POS: hue_next = 9'd240 + dv.hq[8:0];
            argbss_pkg::HC_BLU_NEG: hue_next = 9'd240 - hq_ceil[8:0];
            default:                hue_next = 9'd0;
        endcase
        if (dv.grey)
            hue_next = 9'd0;
        s_raw    = dv.grey ? '0 : dv.sq;
        sprod    = (SW+9)'(s_raw) * (SW+9)'(scale_reg);
        sshift   = sprod[SW+8:8];
        sat_next = (sshift > (SW+1)'(argbss_pkg::ONE)) ? argbss_pkg::ONE : sshift[SW-1:0];
    end

    logic          a_valid_reg;
    logic [7:0]    a_alpha_reg;
    logic [SW-1:0] a_v_reg;
    logic [8:0]    a_hue_reg;
    logic [SW-1:0] a_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= dv.valid;
    end

    always_ff @(posedge clk)
    begin
        a_alpha_reg <= dv.alpha;
        a_v_reg     <= dv.v;
        a_hue_reg   <= hue_next;
        a_sat_reg   <= sat_next;
    end

    // ---------------- stage B: sector and fraction ----------------
    logic [2:0] sector_next;
    logic [8:0] hue_base;
    logic [8:0] hue_mod;

    always_comb
    begin
        if (a_hue_reg < 9'd60)       sector_next = 3'd0;
        else if (a_hue_reg < 9'd120) sector_next = 3'd1;
        else if (a_hue_reg < 9'd180) sector_next = 3'd2;
        else if (a_hue_reg < 9'd240) sector_next = 3'd3;
        else if (a_hue_reg < 9'd300) sector_next = 3'd4;
        else                         sector_next = 3'd5;
        hue_base = 9'(sector_next) * 9'd60;
        hue_mod  = a_hue_reg - hue_base;
    end

    logic          b_valid_reg;
    logic [7:0]    b_alpha_reg;
    logic [SW-1:0] b_v_reg;
    logic [SW-1:0] b_sat_reg;
    logic [SW-1:0] b_f_reg;
    logic [2:0]    b_sector_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_alpha_reg  <= a_alpha_reg;
        b_v_reg      <= a_v_reg;
        b_sat_reg    <= a_sat_reg;
        b_f_reg      <= argbss_pkg::f_of(hue_mod[5:0]);
        b_sector_reg <= sector_next;
    end

    // ---------------- stage C: f*s and (1-f)*s ----------------
    logic [2*SW-1:0] fs_prod, gs_prod;

    always_comb
    begin
        fs_prod = (2*SW)'(b_f_reg) * (2*SW)'(b_sat_reg);
        gs_prod = (2*SW)'(argbss_pkg::ONE - b_f_reg) * (2*SW)'(b_sat_reg);
    end

    logic          c_valid_reg;
    logic [7:0]    c_alpha_reg;
    logic [SW-1:0] c_v_reg;
    logic [SW-1:0] c_fs_reg;
    logic [SW-1:0] c_gs_reg;
    logic [SW-1:0] c_oms_reg;
    logic [2:0]    c_sector_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        c_alpha_reg  <= b_alpha_reg;
        c_v_reg      <= b_v_reg;
        c_fs_reg     <= fs_prod[FB+SW-1:FB];
        c_gs_reg     <= gs_prod[FB+SW-1:FB];
        c_oms_reg    <= argbss_pkg::ONE - b_sat_reg;
        c_sector_reg <= b_sector_reg;
    end

    // ---------------- stage D: p, q, t ----------------
    logic [2*SW-1:0] p_prod, q_prod, t_prod;

    always_comb
    begin
        p_prod = (2*SW)'(c_v_reg) * (2*SW)'(c_oms_reg);
        q_prod = (2*SW)'(c_v_reg) * (2*SW)'(argbss_pkg::ONE - c_fs_reg);
        t_prod = (2*SW)'(c_v_reg) * (2*SW)'(argbss_pkg::ONE - c_gs_reg);
    end

    logic          d_valid_reg;
    logic [7:0]    d_alpha_reg;
    logic [SW-1:0] d_v_reg;
    logic [SW-1:0] d_p_reg;
    logic [SW-1:0] d_q_reg;
    logic [SW-1:0] d_t_reg;
    logic [2:0]    d_sector_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        d_alpha_reg  <= c_alpha_reg;
        d_v_reg      <= c_v_reg;
        d_p_reg      <= p_prod[FB+SW-1:FB];
        d_q_reg      <= q_prod[FB+SW-1:FB];
        d_t_reg      <= t_prod[FB+SW-1:FB];
        d_sector_reg <= c_sector_reg;
    end

    // ---------------- stage E: sector select and pack ----------------
    logic [SW-1:0] ro, go, bo;
    logic [31:0]   pixel_next;

    always_comb
    begin
        case (d_sector_reg)
            3'd0:    begin ro = d_v_reg; go = d_t_reg; bo = d_p_reg; end
            3'd1:    begin ro = d_q_reg; go = d_v_reg; bo = d_p_reg; end
            3'd2:    begin ro = d_p_reg; go = d_v_reg; bo = d_t_reg; end
            3'd3:    begin ro = d_p_reg; go = d_q_reg; bo = d_v_reg; end
            3'd4:    begin ro = d_t_reg; go = d_p_reg; bo = d_v_reg; end
            default: begin ro = d_v_reg; go = d_p_reg; bo = d_q_reg; end
        endcase
        pixel_next = {d_alpha_reg, argbss_pkg::pack_channel(ro),
                      argbss_pkg::pack_channel(go), argbss_pkg::pack_channel(bo)};
    end

    logic        done_reg;
    logic [31:0] pixel_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_valid_reg;
    end

    // load a new word only when one arrives, else hold the last one
    always_ff @(posedge clk)
    begin
        if (d_valid_reg)
            pixel_out_reg <= pixel_next;
    end

    assign done      = done_reg;
    assign pixel_out = pixel_out_reg;

    // ---------------- checks ----------------
    `ASSERT_IMPL(a_sat_clamped, clk, rst_n, a_valid_reg, a_sat_reg <= argbss_pkg::ONE, "saturation above one")
    `ASSERT_IMPL(a_hue_range, clk, rst_n, a_valid_reg, a_hue_reg < 9'd360, "hue out of range")
    `ASSERT_NEXT(a_grey_hue, clk, rst_n, dv.valid && dv.grey, a_hue_reg == 9'd0, "grey pixel hue not zero")
    `ASSERT_NEXT(a_advance, clk, rst_n, b_valid_reg, c_valid_reg, "word dropped in pipeline")

endmodule

// ----- dv/tb_argb_saturation_scaler_core.sv -----
// ----------------------------------------------------------------------------
// tb_argb_saturation_scaler_core
// Self-checking bench for the ARGB saturation scaler. Pixel words are queued
// by an initial block, sent by a bursty driver, and every result word is
// compared with a bit-exact HSV round-trip prediction for the active scale.
// ----------------------------------------------------------------------------
module tb_argb_saturation_scaler_core;

    localparam int FB = argbss_pkg::FRACTION_BITS;
    localparam int LATENCY = argbss_pkg::DIV_STAGES + 6;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] pixel_in;
    logic [31:0] pixel_out;
    logic        done;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    argb_saturation_scaler_core DUT
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_in(pixel_in), .pixel_out(pixel_out), .done(done),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // bench copy of the scale register
    logic [8:0]  sat_scale;
    logic [31:0] pending_words[$];
    logic [31:0] expected_pixels[$];
    int          errors;
    int          words_checked;
    int          burst_left;
    int          gap_left;
    bit          hold_driver;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // channel byte from a fixed-point fraction
    function automatic logic [7:0] to_byte(input longint unsigned x);
        longint unsigned c;
        c = (x * 255) >> FB;
        return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    // predicted output pixel for one input pixel at the given scale
    function automatic logic [31:0] scale_saturation(input logic [31:0] px,
                                                     input logic [8:0] scl);
        longint unsigned one, s, v, f, p, q, t, ro, go, bo;
        int unsigned r, g, b, mx, mn, d, h, m;
        one = longint'(1) << FB;
        r = 32'(px[23:16]);
        g = 32'(px[15:8]);
        b = 32'(px[7:0]);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        // hue; grey pixels get hue zero
        if (d == 0)
            h = 0;
        else if (r == mx)
        begin
            if (g >= b)
                h = ((60 * (g - b)) / d) % 360;
            else
            begin
                m = (60 * (b - g)) / d;
                h = (m == 0) ? 0 : 360 - m;
            end
        end
        else if (g == mx)
            h = (60 * b + 120 * d - 60 * r) / d;
        else
            h = (60 * r + 240 * d - 60 * g) / d;
        s = (mx == 0) ? 0 : ((longint'(d) << FB) / mx);
        v = ((longint'(mx) << FB) + 254) / 255;
        // clamp scaled saturation to one
        s = (s * scl) >> 8;
        if (s > one)
            s = one;
        f = (longint'(h % 60) << FB) / 60;
        p = (v * (one - s)) >> FB;
        q = (v * (one - ((f * s) >> FB))) >> FB;
        t = (v * (one - (((one - f) * s) >> FB))) >> FB;
        case (h / 60)
            0: begin ro = v; go = t; bo = p; end
            1: begin ro = q; go = v; bo = p; end
            2: begin ro = p; go = v; bo = t; end
            3: begin ro = p; go = q; bo = v; end
            4: begin ro = t; go = p; bo = v; end
            default: begin ro = v; go = p; bo = q; end
        endcase
        return {px[31:24], to_byte(ro), to_byte(go), to_byte(bo)};
    endfunction

    // Driver: send queued words in random bursts with random gaps; hold
    // whenever the sequencer asks for a quiet pipeline.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            pixel_in   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_pixels.push_back(scale_saturation(pixel_in, sat_scale));
            if (start && busy)
                ; // hold the offered word
            else if (hold_driver || pending_words.size() == 0)
                start <= 1'b0;
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else
            begin
                start    <= 1'b1;
                pixel_in <= pending_words.pop_front();
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    // long stretches without gaps now and then
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(0, 8);
                    gap_left   <= $urandom_range(0, 4);
                end
            end
        end
    end

    // Monitor: every done cycle must match the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h",
                         $time, pixel_out);
                errors++;
            end
            else
            begin
                logic [31:0] want;
                want = expected_pixels.pop_front();
                words_checked++;
                if (pixel_out !== want)
                begin
                    $display("%0t: pixel_out mismatch, expected %h, actual %h",
                             $time, want, pixel_out);
                    errors++;
                end
            end
        end
    end

    task automatic write_scale(input logic [8:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd4 * argbss_pkg::REG_SAT_SCALE;
        pwdata  <= {23'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sat_scale = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until the pipeline has drained, then hold the driver and settle
    task automatic drain;
        while (pending_words.size() != 0 || start || expected_pixels.size() != 0)
            @(posedge clk);
        hold_driver = 1'b1;
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // random pixel, often grey or with two equal channels
    function automatic logic [31:0] random_pixel;
        logic [31:0] px;
        px = $urandom;
        case ($urandom_range(0, 9))
            0: px[15:0] = {px[23:16], px[23:16]};
            1: px[15:8] = px[23:16];
            2: px[7:0]  = px[15:8];
            3: px[7:0]  = px[23:16];
            default: ;
        endcase
        return px;
    endfunction

    initial
    begin
        logic [8:0]  scales[6];
        logic [31:0] directed[$];
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        sat_scale   = argbss_pkg::SCALE_RESET;
        hold_driver = 1'b1;
        errors      = 0;
        words_checked = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, greys, every hue sector, ties and wrap of red hue
        directed = '{32'h00000000, 32'hFFFFFFFF, 32'h80808080, 32'hFF000000,
                     32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'h12FFFF00,
                     32'h3400FFFF, 32'h56FF00FF, 32'hA0FF8000, 32'hA080FF00,
                     32'hA000FF80, 32'hA00080FF, 32'hA08000FF, 32'hA0FF0080,
                     32'h7FFF00FE, 32'h01010000, 32'h00000001, 32'hFE7F3F1F,
                     32'h55AA55AA};
        scales = '{9'd256, 9'd0, 9'd511, 9'd128, 9'd300, 9'd1};
        foreach (scales[i])
        begin
            write_scale(scales[i]);
            foreach (directed[j])
                pending_words.push_back(directed[j]);
            repeat (260) pending_words.push_back(random_pixel());
            hold_driver = 1'b0;
            drain();
        end
        // random scales with a pause for an empty pipeline between phases
        repeat (3)
        begin
            write_scale(9'($urandom_range(0, 511)));
            repeat (50) pending_words.push_back(random_pixel());
            hold_driver = 1'b0;
            drain();
        end

        $display("Covered %0d pixel words over six fixed and three random scale settings,",
                 words_checked);
        $display("including greys, all hue sectors, channel ties and clamped saturation.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule
